FILE: src/ost_pkg.sv
// ----------------------------------------------------------------------------
// ost_pkg: shared types and codes of the ordered set table
// Holds the request action codes, the fixed result field widths and the
// control group that travels from the sequencer to the entry store.
// ----------------------------------------------------------------------------
package ost_pkg;

  // Fixed field widths of the request and result ports
  localparam int ACTION_W = 2;
  localparam int ELEM_W   = 32;
  localparam int COUNT_W  = 7;

  // Request action codes; the fourth code is ignored
  localparam logic [ACTION_W-1:0] ACT_ADD    = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_SEARCH = 2'd2;

  // Sequencer states, one-hot
  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_SHIFT = 3'b100
  } ost_state_t;

  // Strobes from the sequencer to the entry store
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } ost_mem_ctl_t;

endpackage

FILE: src/ost_store.sv
// ----------------------------------------------------------------------------
// ost_store: entry store of the ordered set table
// Synchronous memory with one write port and one read port; read data is
// registered and appears in the cycle after the read strobe.
// ----------------------------------------------------------------------------
module ost_store #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  logic                      clk,
  input  ost_pkg::ost_mem_ctl_t     ctl,
  input  logic [$clog2(DEPTH)-1:0]  rd_addr,
  output logic [WIDTH-1:0]          rd_data,
  input  logic [$clog2(DEPTH)-1:0]  wr_addr,
  input  logic [WIDTH-1:0]          wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write one entry
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read one entry, registered
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: src/ordered_set_table_top.sv
// ----------------------------------------------------------------------------
// ordered_set_table_top: set of distinct values kept in insertion order
// Each request adds, removes or searches one value. The held values sit in
// one synchronous memory that a sequencer scans, appends to and compacts.
//
//   channel  | handshake            | fields
//   ---------+----------------------+------------------------------------------
//   request  | start & !busy        | in_action, in_elem_value
//   result   | out_valid, 1 cycle   | out_success, out_full_refused,
//            |                      | out_entry_count, out_is_empty
//
// The scan reads one entry a cycle through the memory read port and stops
// once the entry read last compares equal, or once every held entry is read
// for an absent value. A removal then moves every later entry down one place,
// one per cycle. The result strobe shows in the first cycle in which busy is
// low again. Reset clears the count and the control state; the memory needs
// no clearing since places at or beyond the count are never read. Results
// cannot be held off; a new request may start in the cycle that shows the
// result.
// ----------------------------------------------------------------------------
module ordered_set_table_top #(
  parameter int CAPACITY   = 64,
  parameter int VALUE_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [ost_pkg::ACTION_W-1:0]  in_action,
  input  logic signed [ost_pkg::ELEM_W-1:0] in_elem_value,
  output logic                          out_valid,
  output logic                          out_success,
  output logic                          out_full_refused,
  output logic [ost_pkg::COUNT_W-1:0]   out_entry_count,
  output logic                          out_is_empty
);

  localparam int AW    = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  ost_pkg::ost_state_t             state_r, state_nxt;
  logic [ost_pkg::ACTION_W-1:0]    act_r, act_nxt;
  logic [VALUE_BITS-1:0]           key_r, key_nxt;
  logic [CNT_W-1:0]                rd_idx_r, rd_idx_nxt;
  logic [CNT_W-1:0]                cmp_idx_r, cmp_idx_nxt;
  logic                            cmp_vld_r, cmp_vld_nxt;
  logic [CNT_W-1:0]                count_r, count_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic                            out_success_r, out_success_nxt;
  logic                            out_full_r, out_full_nxt;
  logic [ost_pkg::COUNT_W-1:0]     out_count_r;
  logic                            out_empty_r;

  ost_pkg::ost_mem_ctl_t           mem_ctl;
  logic [AW-1:0]                   rd_addr;
  logic [AW-1:0]                   wr_addr;
  logic [VALUE_BITS-1:0]           wr_data;
  logic [VALUE_BITS-1:0]           rd_data;
  logic                            hit;

  ost_store #(
    .DEPTH (CAPACITY),
    .WIDTH (VALUE_BITS)
  ) u_store (
    .clk     (clk),
    .ctl     (mem_ctl),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // Compare the entry read last cycle with the request value
  assign hit = cmp_vld_r && (rd_data == key_r);

  // Sequence scan, append and compaction
  always_comb begin
    state_nxt       = state_r;
    act_nxt         = act_r;
    key_nxt         = key_r;
    rd_idx_nxt      = rd_idx_r;
    cmp_idx_nxt     = cmp_idx_r;
    cmp_vld_nxt     = cmp_vld_r;
    count_nxt       = count_r;
    out_valid_nxt   = 1'b0;
    out_success_nxt = 1'b0;
    out_full_nxt    = 1'b0;
    mem_ctl         = '0;
    rd_addr         = rd_idx_r[AW-1:0];
    wr_addr         = count_r[AW-1:0];
    wr_data         = key_r;
    unique case (state_r)
      ost_pkg::ST_IDLE: begin
        // Take a request and start the scan at the first entry
        if (start) begin
          act_nxt     = in_action;
          key_nxt     = VALUE_BITS'($unsigned(in_elem_value));
          rd_idx_nxt  = '0;
          cmp_vld_nxt = 1'b0;
          state_nxt   = ost_pkg::ST_SCAN;
        end
      end
      ost_pkg::ST_SCAN: begin
        priority if (hit) begin
          // Value held: remove compacts, search reports, add is refused
          cmp_vld_nxt = 1'b0;
          if (act_r == ost_pkg::ACT_REMOVE) begin
            rd_idx_nxt = cmp_idx_r + CNT_W'(1);
            state_nxt  = ost_pkg::ST_SHIFT;
          end else begin
            out_valid_nxt   = 1'b1;
            out_success_nxt = (act_r == ost_pkg::ACT_SEARCH);
            state_nxt       = ost_pkg::ST_IDLE;
          end
        end else if (rd_idx_r < count_r) begin
          // Read the next entry
          mem_ctl.rd_en = 1'b1;
          cmp_idx_nxt   = rd_idx_r;
          cmp_vld_nxt   = 1'b1;
          rd_idx_nxt    = rd_idx_r + CNT_W'(1);
        end else begin
          // Value absent: append on add unless full
          cmp_vld_nxt   = 1'b0;
          out_valid_nxt = 1'b1;
          state_nxt     = ost_pkg::ST_IDLE;
          if (act_r == ost_pkg::ACT_ADD) begin
            if (count_r == CAP_CNT) begin
              out_full_nxt = 1'b1;
            end else begin
              mem_ctl.wr_en   = 1'b1;
              count_nxt       = count_r + CNT_W'(1);
              out_success_nxt = 1'b1;
            end
          end
        end
      end
      ost_pkg::ST_SHIFT: begin
        // Move the entry read last cycle down one place
        if (cmp_vld_r) begin
          mem_ctl.wr_en = 1'b1;
          wr_addr       = AW'(cmp_idx_r - CNT_W'(1));
          wr_data       = rd_data;
        end
        if (rd_idx_r < count_r) begin
          mem_ctl.rd_en = 1'b1;
          cmp_idx_nxt   = rd_idx_r;
          cmp_vld_nxt   = 1'b1;
          rd_idx_nxt    = rd_idx_r + CNT_W'(1);
        end else begin
          cmp_vld_nxt     = 1'b0;
          count_nxt       = count_r - CNT_W'(1);
          out_valid_nxt   = 1'b1;
          out_success_nxt = 1'b1;
          state_nxt       = ost_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ost_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ost_pkg::ST_IDLE;
      count_r     <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Request and scan payload registers
  always_ff @(posedge clk) begin
    act_r     <= act_nxt;
    key_r     <= key_nxt;
    rd_idx_r  <= rd_idx_nxt;
    cmp_idx_r <= cmp_idx_nxt;
  end

  // Hold the result fields for the strobe cycle
  always_ff @(posedge clk) begin
    if (out_valid_nxt) begin
      out_success_r <= out_success_nxt;
      out_full_r    <= out_full_nxt;
      out_count_r   <= ost_pkg::COUNT_W'(count_nxt);
      out_empty_r   <= (count_nxt == '0);
    end
  end

  assign busy             = (state_r != ost_pkg::ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_success      = out_success_r;
  assign out_full_refused = out_full_r;
  assign out_entry_count  = out_count_r;
  assign out_is_empty     = out_empty_r;

  // A result strobe is never directly followed by another
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for two cycles");

  // Count never passes the capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_CNT)
    else $error("entry count beyond capacity");

  // A refusal for lack of room reports no success and a full store
  a_full_refusal: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_full_refused) |-> (!out_success && count_r == CAP_CNT))
    else $error("full refusal with success or room left");

  // Busy rises only on an accepted request
  a_busy_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start))
    else $error("busy raised without a request");

endmodule
